FILE: rtl/ordered_dither_palette_mapper_assert.svh
// Assertion helpers for the ordered dither palette mapper.
`ifndef ORDERED_DITHER_PALETTE_MAPPER_ASSERT_SVH
`define ORDERED_DITHER_PALETTE_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ODPM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ODPM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/odpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package odpm_pkg;

    localparam logic [1:0] FUNC_PIXEL       = 2'd0;
    localparam logic [1:0] FUNC_LOAD_MAP    = 2'd1;
    localparam logic [1:0] FUNC_LOAD_QUANT  = 2'd2;
    localparam logic [1:0] FUNC_LOAD_DITHER = 2'd3;

    localparam logic [1:0] CFG_COLOR_MODE    = 2'd0;
    localparam logic [1:0] CFG_USE_MAP       = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;
    localparam logic [1:0] CFG_PALETTE_BASE  = 2'd3;

    localparam int CHANNELS  = 3;
    localparam int MAP_DEPTH = 256;
    localparam int POS_W     = 12;
    localparam int MOD_SHIFT = 16;

    localparam int SUM_W = 15;
    localparam logic [SUM_W-1:0] LUM_W_RED   = 15'd35;
    localparam logic [SUM_W-1:0] LUM_W_GREEN = 15'd55;
    localparam logic [SUM_W-1:0] LUM_W_BLUE  = 15'd10;

    localparam int LUM_DIV         = 100;
    localparam int LUM_DIV_SHIFT   = 22;
    localparam int LUM_DIV_MULT    = ((1 << LUM_DIV_SHIFT) + LUM_DIV - 1) / LUM_DIV;
    localparam int LUM_DIV_MULT_W  = $clog2(LUM_DIV_MULT + 1);
    localparam int LUM_PROD_W      = SUM_W + LUM_DIV_MULT_W;

    localparam logic [7:0] GREEN_STRIDE = 8'd6;
    localparam logic [7:0] BLUE_STRIDE  = 8'd36;

    typedef struct packed {
        logic       we;
        logic [7:0] idx;
        logic [7:0] quot;
        logic [7:0] rem;
    } odpm_qload_t;

endpackage

`default_nettype wire

FILE: rtl/odpm_quant_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module odpm_quant_lane #(
    parameter int LEVEL_COUNT = 256
) (
    input  logic                 aclk,
    input  logic                 en,
    input  odpm_pkg::odpm_qload_t load,
    input  logic [7:0]           level_in,
    input  logic [7:0]           threshold,
    output logic [7:0]           level_out
);
    import odpm_pkg::*;

    localparam int LW = $clog2(LEVEL_COUNT);

    logic [15:0]   qr_mem [LEVEL_COUNT];
    logic [15:0]   qr_rd_reg;
    logic [LW-1:0] raddr;

    // saturate lookups beyond the table
    assign raddr = ({1'b0, level_in} < 9'(LEVEL_COUNT)) ? level_in[LW-1:0]
                                                        : LW'(LEVEL_COUNT - 1);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (load.we) begin
                qr_mem[load.idx[LW-1:0]] <= {load.quot, load.rem};
            end
            qr_rd_reg <= qr_mem[raddr];
        end
    end

    assign level_out = qr_rd_reg[15:8] + 8'(qr_rd_reg[7:0] > threshold);

endmodule

`default_nettype wire

FILE: rtl/ordered_dither_palette_mapper.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_dither_palette_mapper_assert.svh"

// Ordered dither palette mapper.
// Input channel (s_*): one transaction per pixel or table load, selected by s_func.
// Pixel transactions give one m_palette_index transaction; table loads give none.
// Loads write the channel maps, the quantiser quotient/remainder tables and the
// dither threshold table; a load takes effect for every transaction behind it.
// Configuration (cfg_*): write only while no transaction is in flight.
// A pixel passes the stage 1 to 4 registers and the output register to m_valid.
// Throughput: one transaction per cycle unless the output stalls. Map and quantiser
// tables have a read port per lane, the dither table one; loads write where each is read.
// A stalled receiver holds the output register and freezes the whole pipeline;
// s_ready drops only during reset or while m_valid is high and m_ready is low.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// configuration registers; table contents are undefined until loaded.
module ordered_dither_palette_mapper #(
    parameter int LEVEL_COUNT = 256,
    parameter int DITHER_SIDE = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [11:0] s_x_pos,
    input  logic [11:0] s_y_pos,
    input  logic [1:0]  s_table_channel,
    input  logic [7:0]  s_table_index,
    input  logic [7:0]  s_table_value,
    input  logic [7:0]  s_table_remainder,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_palette_index,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import odpm_pkg::*;

    localparam int DW         = $clog2(DITHER_SIDE);
    localparam int DEPTH_D    = DITHER_SIDE * DITHER_SIDE;
    localparam int DAW        = $clog2(DEPTH_D);
    localparam int MOD_MULT   = ((1 << MOD_SHIFT) + DITHER_SIDE - 1) / DITHER_SIDE;
    localparam int MOD_MULT_W = $clog2(MOD_MULT + 1);
    localparam int MOD_PROD_W = POS_W + MOD_MULT_W;
    localparam int MOD_QUO_W  = MOD_PROD_W - MOD_SHIFT;

    // configuration
    logic       color_mode_reg;
    logic       use_map_reg;
    logic [1:0] channel_count_reg;
    logic [7:0] palette_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg    <= 1'b0;
            use_map_reg       <= 1'b1;
            channel_count_reg <= 2'd3;
            palette_base_reg  <= 8'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COLOR_MODE:    color_mode_reg    <= cfg_data[0];
                CFG_USE_MAP:       use_map_reg       <= cfg_data[0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[1:0];
                CFG_PALETTE_BASE:  palette_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic adv;
    logic accept;
    logic m_valid_reg;
    logic [7:0] m_palette_index_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = aresetn && adv;
    assign accept  = s_valid && s_ready;

    // stage 0: channel fill, map read, position scaling
    logic [7:0]            samp_next [CHANNELS];
    logic [MOD_PROD_W-1:0] xprod_next;
    logic [MOD_PROD_W-1:0] yprod_next;
    logic [7:0]            map_rd [CHANNELS];

    always_comb begin
        samp_next[0] = s_red;
        samp_next[1] = (channel_count_reg < 2'd2) ? s_red : s_green;
        samp_next[2] = (channel_count_reg < 2'd3) ? s_red : s_blue;
    end

    assign xprod_next = MOD_PROD_W'(s_x_pos) * MOD_PROD_W'(MOD_MULT);
    assign yprod_next = MOD_PROD_W'(s_y_pos) * MOD_PROD_W'(MOD_MULT);

    for (genvar c = 0; c < CHANNELS; c++) begin : g_map
        logic [7:0] map_mem [MAP_DEPTH];
        logic [7:0] map_rd_reg;

        always_ff @(posedge aclk) begin
            if (accept && (s_func == FUNC_LOAD_MAP) && (s_table_channel == 2'(c))) begin
                map_mem[s_table_index] <= s_table_value;
            end
            if (adv) begin
                map_rd_reg <= map_mem[samp_next[c]];
            end
        end

        assign map_rd[c] = map_rd_reg;
    end

    // stage 1
    logic                  p1_valid_reg;
    logic [1:0]            p1_func_reg;
    logic [7:0]            p1_samp_reg [CHANNELS];
    logic [POS_W-1:0]      p1_x_reg;
    logic [POS_W-1:0]      p1_y_reg;
    logic [MOD_PROD_W-1:0] p1_xprod_reg;
    logic [MOD_PROD_W-1:0] p1_yprod_reg;
    logic [7:0]            p1_idx_reg;
    logic [7:0]            p1_val_reg;
    logic [7:0]            p1_rem_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_func_reg  <= s_func;
            p1_samp_reg  <= samp_next;
            p1_x_reg     <= s_x_pos;
            p1_y_reg     <= s_y_pos;
            p1_xprod_reg <= xprod_next;
            p1_yprod_reg <= yprod_next;
            p1_idx_reg   <= s_table_index;
            p1_val_reg   <= s_table_value;
            p1_rem_reg   <= s_table_remainder;
        end
    end

    logic [MOD_QUO_W-1:0] x_quo;
    logic [MOD_QUO_W-1:0] y_quo;
    logic [DW-1:0]        col_next;
    logic [DW-1:0]        row_next;
    logic [7:0]           seff [CHANNELS];
    logic [SUM_W-1:0]     wsum_next;

    assign x_quo    = p1_xprod_reg[MOD_PROD_W-1:MOD_SHIFT];
    assign y_quo    = p1_yprod_reg[MOD_PROD_W-1:MOD_SHIFT];
    assign col_next = DW'(p1_x_reg - POS_W'(POS_W'(x_quo) * POS_W'(DITHER_SIDE)));
    assign row_next = DW'(p1_y_reg - POS_W'(POS_W'(y_quo) * POS_W'(DITHER_SIDE)));

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            seff[c] = use_map_reg ? map_rd[c] : p1_samp_reg[c];
        end
    end

    assign wsum_next = SUM_W'(seff[0]) * LUM_W_RED
                     + SUM_W'(seff[1]) * LUM_W_GREEN
                     + SUM_W'(seff[2]) * LUM_W_BLUE;

    // stage 2
    logic             p2_valid_reg;
    logic [1:0]       p2_func_reg;
    logic [7:0]       p2_samp_reg [CHANNELS];
    logic [DW-1:0]    p2_col_reg;
    logic [DW-1:0]    p2_row_reg;
    logic [SUM_W-1:0] p2_wsum_reg;
    logic [7:0]       p2_idx_reg;
    logic [7:0]       p2_val_reg;
    logic [7:0]       p2_rem_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_func_reg <= p1_func_reg;
            p2_samp_reg <= seff;
            p2_col_reg  <= col_next;
            p2_row_reg  <= row_next;
            p2_wsum_reg <= wsum_next;
            p2_idx_reg  <= p1_idx_reg;
            p2_val_reg  <= p1_val_reg;
            p2_rem_reg  <= p1_rem_reg;
        end
    end

    logic [DAW-1:0]        dith_addr_next;
    logic [LUM_PROD_W-1:0] lum_prod_next;

    assign dith_addr_next = DAW'(DAW'(p2_col_reg) * DAW'(DITHER_SIDE) + DAW'(p2_row_reg));
    assign lum_prod_next  = LUM_PROD_W'(p2_wsum_reg) * LUM_PROD_W'(LUM_DIV_MULT);

    // stage 3: quantiser and threshold reads, quantiser and threshold table loads
    logic                  p3_valid_reg;
    logic [1:0]            p3_func_reg;
    logic [7:0]            p3_samp_reg [CHANNELS];
    logic [DAW-1:0]        p3_dith_addr_reg;
    logic [LUM_PROD_W-1:0] p3_lum_prod_reg;
    logic [7:0]            p3_idx_reg;
    logic [7:0]            p3_val_reg;
    logic [7:0]            p3_rem_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_func_reg      <= p2_func_reg;
            p3_samp_reg      <= p2_samp_reg;
            p3_dith_addr_reg <= dith_addr_next;
            p3_lum_prod_reg  <= lum_prod_next;
            p3_idx_reg       <= p2_idx_reg;
            p3_val_reg       <= p2_val_reg;
            p3_rem_reg       <= p2_rem_reg;
        end
    end

    logic [7:0]  lum;
    logic [7:0]  lane_in [CHANNELS];
    logic [7:0]  lane_level [CHANNELS];
    odpm_qload_t qload;
    logic        dith_we;
    logic [7:0]  dith_mem [DEPTH_D];
    logic [7:0]  dith_rd_reg;

    assign lum = p3_lum_prod_reg[LUM_DIV_SHIFT +: 8];

    always_comb begin
        lane_in[0] = color_mode_reg ? lum : p3_samp_reg[0];
        lane_in[1] = p3_samp_reg[1];
        lane_in[2] = p3_samp_reg[2];
    end

    assign qload.we   = p3_valid_reg && (p3_func_reg == FUNC_LOAD_QUANT)
                        && ({1'b0, p3_idx_reg} < 9'(LEVEL_COUNT));
    assign qload.idx  = p3_idx_reg;
    assign qload.quot = p3_val_reg;
    assign qload.rem  = p3_rem_reg;

    assign dith_we = p3_valid_reg && (p3_func_reg == FUNC_LOAD_DITHER)
                     && ({1'b0, p3_idx_reg} < 9'(DEPTH_D));

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dith_we) begin
                dith_mem[p3_idx_reg[DAW-1:0]] <= p3_val_reg;
            end
            dith_rd_reg <= dith_mem[p3_dith_addr_reg];
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        odpm_quant_lane #(
            .LEVEL_COUNT(LEVEL_COUNT)
        ) u_lane (
            .aclk     (aclk),
            .en       (adv),
            .load     (qload),
            .level_in (lane_in[c]),
            .threshold(dith_rd_reg),
            .level_out(lane_level[c])
        );
    end

    // stage 4: pack
    logic       p4_valid_reg;
    logic [1:0] p4_func_reg;
    logic [7:0] res_next;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_func_reg <= p3_func_reg;
        end
    end

    assign res_next = color_mode_reg
                    ? lane_level[0] + palette_base_reg
                    : lane_level[0] + GREEN_STRIDE * lane_level[1]
                      + BLUE_STRIDE * lane_level[2] + palette_base_reg;

    // valid chain and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            m_valid_reg  <= p4_valid_reg && (p4_func_reg == FUNC_PIXEL);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_palette_index_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_palette_index = m_palette_index_reg;

    `ODPM_ASSERT_NEXT(a_pixel_emits, aclk, aresetn, adv && p4_valid_reg && (p4_func_reg == FUNC_PIXEL), m_valid_reg, "pixel transaction dropped before output")
    `ODPM_ASSERT_NEXT(a_load_silent, aclk, aresetn, adv && p4_valid_reg && (p4_func_reg != FUNC_PIXEL), !m_valid_reg, "table load produced an output transaction")
    `ODPM_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, !adv, $stable(p3_valid_reg) && $stable(p4_valid_reg) && $stable(m_palette_index_reg), "pipeline moved during output stall")
    `ODPM_ASSERT_NOW(a_ready_stall, aclk, aresetn, !s_ready, m_valid_reg && !m_ready, "input blocked without output stall")

endmodule

`default_nettype wire

FILE: tb/sv/ordered_dither_palette_mapper_tb.sv
`timescale 1ns / 1ps

module ordered_dither_palette_mapper_tb;
    import odpm_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SWEEP_LEN     = 7;

    localparam logic [1:0] CH_RED     = 2'd0;
    localparam logic [1:0] CH_GREEN   = 2'd1;
    localparam logic [1:0] CH_BLUE    = 2'd2;
    localparam logic [1:0] CH_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [1:0]  table_channel;
        logic [7:0]  table_index;
        logic [7:0]  table_value;
        logic [7:0]  table_remainder;
    } odpm_item_t;

    typedef struct packed {
        odpm_item_t item;
        logic       typed;
        logic [7:0] palette;
    } directed_row_t;

    typedef struct packed {
        logic       color_mode;
        logic       use_map;
        logic [1:0] channel_count;
        logic [7:0] palette_base;
    } mapper_cfg_t;

    localparam directed_row_t DIRECTED [16] = '{
        '{'{FUNC_LOAD_MAP, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_RED, 8'd0, 8'd0, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_LOAD_MAP, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_GREEN, 8'd0, 8'd0, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_LOAD_MAP, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_BLUE, 8'd0, 8'd0, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_LOAD_QUANT, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_RED, 8'd0, 8'd0, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_LOAD_DITHER, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_RED, 8'd0, 8'd0, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_RED, 8'd0, 8'd0, 8'd0},
          1'b1, 8'd8},
        '{'{FUNC_LOAD_MAP, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_RED, 8'd255, 8'd255, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_LOAD_MAP, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_GREEN, 8'd255, 8'd255, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_LOAD_MAP, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_BLUE, 8'd255, 8'd255, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_LOAD_QUANT, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_RED, 8'd255, 8'd5, 8'd255},
          1'b0, 8'd0},
        '{'{FUNC_LOAD_DITHER, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_RED, 8'd255, 8'd255, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_PIXEL, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, CH_RED, 8'd0, 8'd0, 8'd0},
          1'b1, 8'd223},
        '{'{FUNC_LOAD_DITHER, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_RED, 8'd240, 8'd0, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_PIXEL, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd4080, CH_RED, 8'd0, 8'd0, 8'd0},
          1'b1, 8'd10},
        '{'{FUNC_LOAD_MAP, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, CH_INVALID, 8'd0, 8'hAA, 8'd0},
          1'b0, 8'd0},
        '{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 12'd4080, 12'd16, CH_RED, 8'd0, 8'd0, 8'd0},
          1'b1, 8'd8}
    };

    localparam mapper_cfg_t CFG_SWEEP [SWEEP_LEN] = '{
        '{1'b0, 1'b0, 2'd3, 8'd0},
        '{1'b1, 1'b1, 2'd3, 8'd255},
        '{1'b1, 1'b0, 2'd1, 8'd128},
        '{1'b0, 1'b1, 2'd0, 8'd200},
        '{1'b0, 1'b1, 2'd2, 8'd8},
        '{1'b1, 1'b1, 2'd0, 8'd77},
        '{1'b0, 1'b1, 2'd3, 8'd255}
    };

    localparam logic [1:0] LOAD_FUNCS [3] = '{FUNC_LOAD_MAP, FUNC_LOAD_QUANT, FUNC_LOAD_DITHER};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_PIXEL;
    logic [7:0]  s_red = '0;
    logic [7:0]  s_green = '0;
    logic [7:0]  s_blue = '0;
    logic [11:0] s_x_pos = '0;
    logic [11:0] s_y_pos = '0;
    logic [1:0]  s_table_channel = CH_RED;
    logic [7:0]  s_table_index = '0;
    logic [7:0]  s_table_value = '0;
    logic [7:0]  s_table_remainder = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_palette_index;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_COLOR_MODE;
    logic [7:0]  cfg_data = '0;

    logic [7:0]  chan_map [3][256];
    logic [7:0]  quot_tbl [256];
    logic [7:0]  rem_tbl [256];
    logic [7:0]  thresh_tbl [256];
    bit          map_loaded [3][256];
    bit          quant_loaded [256];
    bit          thresh_loaded [256];

    mapper_cfg_t cur_cfg = '{1'b0, 1'b1, 2'd3, 8'd8};
    logic [7:0]  palette_expected [$];

    int error_count = 0;
    int cycle_count = 0;
    int rx_tick = 0;
    int burst_left = 0;
    int items_sent = 0;

    ordered_dither_palette_mapper uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_red             (s_red),
        .s_green           (s_green),
        .s_blue            (s_blue),
        .s_x_pos           (s_x_pos),
        .s_y_pos           (s_y_pos),
        .s_table_channel   (s_table_channel),
        .s_table_index     (s_table_index),
        .s_table_value     (s_table_value),
        .s_table_remainder (s_table_remainder),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_palette_index   (m_palette_index),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned dithered_level(logic [7:0] lvl, logic [7:0] thr_addr);
        if (rem_tbl[lvl] > thresh_tbl[thr_addr]) begin
            return 32'(quot_tbl[lvl]) + 1;
        end
        return 32'(quot_tbl[lvl]);
    endfunction

    function automatic logic [2:0][7:0] present_samples(odpm_item_t it);
        logic [2:0][7:0] smp;
        smp[0] = it.red;
        smp[1] = it.green;
        smp[2] = it.blue;
        if (cur_cfg.channel_count < 2'd3) begin
            smp[2] = it.red;
        end
        if (cur_cfg.channel_count < 2'd2) begin
            smp[1] = it.red;
        end
        return smp;
    endfunction

    function automatic logic [2:0][7:0] mapped_samples(logic [2:0][7:0] raw);
        logic [2:0][7:0] smp;
        for (int c = 0; c < 3; c++) begin
            smp[c] = cur_cfg.use_map ? chan_map[c][raw[c]] : raw[c];
        end
        return smp;
    endfunction

    function automatic logic [7:0] luminance(logic [2:0][7:0] smp);
        int unsigned weighted;
        weighted = 35 * smp[0] + 55 * smp[1] + 10 * smp[2];
        return 8'(weighted / 100);
    endfunction

    function automatic bit apply_transaction(odpm_item_t it, output logic [7:0] palette);
        logic [2:0][7:0] lvl;
        logic [7:0]      thr_addr;
        int unsigned     level_sum;
        bit              gives_result;
        gives_result = 1'b0;
        palette = '0;
        case (it.func)
            FUNC_LOAD_MAP: begin
                if (it.table_channel != CH_INVALID) begin
                    chan_map[it.table_channel][it.table_index] = it.table_value;
                    map_loaded[it.table_channel][it.table_index] = 1'b1;
                end
            end
            FUNC_LOAD_QUANT: begin
                quot_tbl[it.table_index] = it.table_value;
                rem_tbl[it.table_index] = it.table_remainder;
                quant_loaded[it.table_index] = 1'b1;
            end
            FUNC_LOAD_DITHER: begin
                thresh_tbl[it.table_index] = it.table_value;
                thresh_loaded[it.table_index] = 1'b1;
            end
            FUNC_PIXEL: begin
                lvl = mapped_samples(present_samples(it));
                thr_addr = {it.x_pos[3:0], it.y_pos[3:0]};
                if (cur_cfg.color_mode) begin
                    level_sum = dithered_level(luminance(lvl), thr_addr);
                end else begin
                    level_sum = dithered_level(lvl[0], thr_addr)
                              + 6 * dithered_level(lvl[1], thr_addr)
                              + 36 * dithered_level(lvl[2], thr_addr);
                end
                palette = 8'(level_sum + 32'(cur_cfg.palette_base));
                gives_result = 1'b1;
            end
            default: begin
            end
        endcase
        return gives_result;
    endfunction

    function automatic logic [7:0] sample_value();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic odpm_item_t random_item(logic [1:0] func);
        odpm_item_t it;
        it.func = func;
        it.red = sample_value();
        it.green = sample_value();
        it.blue = sample_value();
        it.x_pos = 12'($urandom());
        it.y_pos = 12'($urandom());
        it.table_channel = 2'($urandom());
        it.table_index = 8'($urandom());
        it.table_value = sample_value();
        it.table_remainder = sample_value();
        return it;
    endfunction

    function automatic void report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    task automatic send_item(odpm_item_t it, bit typed, logic [7:0] typed_palette);
        logic [7:0] predicted;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 9) : 1) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_func <= it.func;
        s_red <= it.red;
        s_green <= it.green;
        s_blue <= it.blue;
        s_x_pos <= it.x_pos;
        s_y_pos <= it.y_pos;
        s_table_channel <= it.table_channel;
        s_table_index <= it.table_index;
        s_table_value <= it.table_value;
        s_table_remainder <= it.table_remainder;
        do @(posedge aclk); while (!s_ready);
        if (apply_transaction(it, predicted)) begin
            palette_expected.push_back(typed ? typed_palette : predicted);
        end
        items_sent++;
    endtask

    task automatic send_load(logic [1:0] func, logic [1:0] chan, logic [7:0] index);
        odpm_item_t it;
        it = random_item(func);
        it.table_channel = chan;
        it.table_index = index;
        send_item(it, 1'b0, 8'h00);
    endtask

    // load every entry the pixel will read before sending it
    task automatic send_pixel(odpm_item_t px);
        logic [2:0][7:0] raw;
        logic [2:0][7:0] lvl;
        logic [7:0]      thr_addr;
        raw = present_samples(px);
        for (int c = 0; c < 3; c++) begin
            if (!map_loaded[c][raw[c]]) begin
                send_load(FUNC_LOAD_MAP, 2'(c), raw[c]);
            end
        end
        lvl = mapped_samples(raw);
        for (int c = 0; c < 3; c++) begin
            if (!quant_loaded[lvl[c]]) begin
                send_load(FUNC_LOAD_QUANT, CH_RED, lvl[c]);
            end
        end
        if (!quant_loaded[luminance(lvl)]) begin
            send_load(FUNC_LOAD_QUANT, CH_RED, luminance(lvl));
        end
        thr_addr = {px.x_pos[3:0], px.y_pos[3:0]};
        if (!thresh_loaded[thr_addr]) begin
            send_load(FUNC_LOAD_DITHER, CH_RED, thr_addr);
        end
        send_item(px, 1'b0, 8'h00);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (palette_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(mapper_cfg_t cfg);
        cfg_we <= 1'b1;
        cfg_index <= CFG_COLOR_MODE;
        cfg_data <= {7'd0, cfg.color_mode};
        @(posedge aclk);
        cfg_index <= CFG_USE_MAP;
        cfg_data <= {7'd0, cfg.use_map};
        @(posedge aclk);
        cfg_index <= CFG_CHANNEL_COUNT;
        cfg_data <= {6'd0, cfg.channel_count};
        @(posedge aclk);
        cfg_index <= CFG_PALETTE_BASE;
        cfg_data <= cfg.palette_base;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_cfg = cfg;
    endtask

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        case (rx_tick[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_tick[3:0] < 4'd3);
        endcase
    end

    always @(posedge aclk) begin : result_check
        logic [7:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (palette_expected.size() == 0) begin
                report_mismatch("unexpected palette index", 8'h00, m_palette_index);
            end else begin
                want = palette_expected.pop_front();
                if (m_palette_index !== want) begin
                    report_mismatch("palette index mismatch", want, m_palette_index);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("ordered_dither_palette_mapper_tb: errors");
            $finish;
        end
    end

    initial begin
        int phase_end;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].palette);
        end

        for (int p = 0; p < SWEEP_LEN; p++) begin
            drain_results();
            write_config(CFG_SWEEP[p]);
            phase_end = items_sent + RANDOM_ITEMS / SWEEP_LEN;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) < 7) begin
                    send_pixel(random_item(FUNC_PIXEL));
                end else begin
                    send_item(random_item(LOAD_FUNCS[$urandom_range(0, 2)]), 1'b0, 8'h00);
                end
            end
        end

        drain_results();
        if (error_count == 0) begin
            $display("ordered_dither_palette_mapper_tb: clean");
        end else begin
            $display("ordered_dither_palette_mapper_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/odpm_pkg.sv
rtl/odpm_quant_lane.sv
rtl/ordered_dither_palette_mapper.sv
tb/sv/ordered_dither_palette_mapper_tb.sv
